@@ design/fmbq_pkg.sv @@
`timescale 1ns / 1ps

package fmbq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -1;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT  = 3'd0,
    KIND_PUSH_MIDDLE = 3'd1,
    KIND_PUSH_BACK   = 3'd2,
    KIND_POP_FRONT   = 3'd3,
    KIND_POP_MIDDLE  = 3'd4,
    KIND_POP_BACK    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_PLACE,
    ST_FETCH,
    ST_CAPTURE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    status_e                  status;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // latch a new item
    logic fetch;    // read the entry at the cursor
    logic move_rd;  // read the neighbor of the cursor
    logic move_wr;  // write the neighbor data at the cursor, step the cursor
    logic place;    // write the pushed value at the cursor, grow the count
    logic capture;  // keep the fetched value, shrink the count
    logic emit;     // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic push_ok;
    logic pop_ok;
    logic at_end;
    logic next_at_end;
    logic out_free;
  } stat_t;

endpackage

@@ design/front_middle_back_queue.sv @@
`timescale 1ns / 1ps
// Sequence: after decode, an item that stores nothing (refused push, pop on empty, spare kind)
//   goes to done; a push shifts k entries then places; a pop fetches, captures, then shifts k.
// One item at a time: done holds while a held result blocks the output;
//   k is up to CAPACITY - 1, as the entry memory moves one entry per read/write state pair.
// Reset: asynchronous, active low; clears the fill count, controller state and output valid.
//   Entry storage is not cleared.

module front_middle_back_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fmbq_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fmbq_pkg::rsp_t out_rsp_o
);

  // Command and status between sequencer and storage/datapath
  fmbq_pkg::cmd_t  cmd;
  fmbq_pkg::stat_t stat;

  // Sequencer: decode the item, walk the shift, then hand the result to the output register.
  // A new item is taken only in idle; the previous result may still sit in the output
  // register, and the controller holds in done until that register frees up.
  fmbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Entry memory, fill count, shift cursor and output register.
  // Insert: walk the cursor from the back down to the target, copying each entry one slot
  // back, then write the new value. Remove: read the target, then walk toward the back
  // copying each entry one slot forward.
  fmbq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

`ifndef ASSERT_OFF
  // One item at a time: in the cycle after an accept the input side is closed
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // An empty-pop result always carries the -1 marker
  a_empty_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status == fmbq_pkg::STATUS_EMPTY))
      |-> (out_rsp_o.pop_value == fmbq_pkg::EMPTY_VALUE))
    else $error("empty pop without -1 value");

  // A rejected push returns zero
  a_full_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status == fmbq_pkg::STATUS_FULL))
      |-> (out_rsp_o.pop_value == '0))
    else $error("full push with nonzero value");

  // Memory is never read and written by the same command
  a_port_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.move_wr || cmd.place) |-> !(cmd.fetch || cmd.move_rd))
    else $error("memory read and write commanded together");
`endif

endmodule

@@ design/fmbq_ctrl.sv @@
`timescale 1ns / 1ps

module fmbq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fmbq_pkg::stat_t stat_i,
  output fmbq_pkg::cmd_t  cmd_o
);

  fmbq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmbq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fmbq_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = fmbq_pkg::ST_DECODE;
      end
      fmbq_pkg::ST_DECODE: begin
        if (stat_i.push_ok) begin
          state_d = stat_i.at_end ? fmbq_pkg::ST_PLACE : fmbq_pkg::ST_MOVE_RD;
        end else if (stat_i.pop_ok) begin
          state_d = fmbq_pkg::ST_FETCH;
        end else begin
          state_d = fmbq_pkg::ST_DONE;
        end
      end
      fmbq_pkg::ST_MOVE_RD: state_d = fmbq_pkg::ST_MOVE_WR;
      fmbq_pkg::ST_MOVE_WR: begin
        if (!stat_i.next_at_end) begin
          state_d = fmbq_pkg::ST_MOVE_RD;
        end else begin
          state_d = stat_i.push_ok ? fmbq_pkg::ST_PLACE : fmbq_pkg::ST_DONE;
        end
      end
      fmbq_pkg::ST_PLACE:   state_d = fmbq_pkg::ST_DONE;
      fmbq_pkg::ST_FETCH:   state_d = fmbq_pkg::ST_CAPTURE;
      fmbq_pkg::ST_CAPTURE: begin
        state_d = stat_i.at_end ? fmbq_pkg::ST_DONE : fmbq_pkg::ST_MOVE_RD;
      end
      fmbq_pkg::ST_DONE: begin
        if (stat_i.out_free) state_d = fmbq_pkg::ST_IDLE;
      end
      default: state_d = fmbq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      fmbq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      fmbq_pkg::ST_MOVE_RD: cmd_o.move_rd = 1'b1;
      fmbq_pkg::ST_MOVE_WR: cmd_o.move_wr = 1'b1;
      fmbq_pkg::ST_PLACE:   cmd_o.place   = 1'b1;
      fmbq_pkg::ST_FETCH:   cmd_o.fetch   = 1'b1;
      fmbq_pkg::ST_CAPTURE: cmd_o.capture = 1'b1;
      fmbq_pkg::ST_DONE:    cmd_o.emit    = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ design/fmbq_datapath.sv @@
`timescale 1ns / 1ps

module fmbq_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fmbq_pkg::req_t  in_req_i,
  input  fmbq_pkg::cmd_t  cmd_i,
  output fmbq_pkg::stat_t stat_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fmbq_pkg::rsp_t  out_rsp_o
);

  logic signed [fmbq_pkg::DATA_W-1:0] mem [fmbq_pkg::CAPACITY];

  logic [fmbq_pkg::CNT_W-1:0]  count_q;
  logic [fmbq_pkg::IDX_W-1:0]  ptr_q, pos_q, last_q;
  logic                        push_ok_q, pop_ok_q;
  logic signed [fmbq_pkg::DATA_W-1:0] value_q, rd_data_q, res_val_q;
  fmbq_pkg::status_e           res_st_q;
  logic                        out_valid_q;
  fmbq_pkg::rsp_t              out_rsp_q;

  logic                        is_push, is_pop, full, empty;
  logic [fmbq_pkg::CNT_W-1:0]  count_m1;
  logic [fmbq_pkg::IDX_W-1:0]  pos_d, ptr_dec, ptr_inc, rd_addr;
  logic                        rd_en, wr_en;

  assign is_push = (in_req_i.kind == fmbq_pkg::KIND_PUSH_FRONT)
                || (in_req_i.kind == fmbq_pkg::KIND_PUSH_MIDDLE)
                || (in_req_i.kind == fmbq_pkg::KIND_PUSH_BACK);
  assign is_pop  = (in_req_i.kind == fmbq_pkg::KIND_POP_FRONT)
                || (in_req_i.kind == fmbq_pkg::KIND_POP_MIDDLE)
                || (in_req_i.kind == fmbq_pkg::KIND_POP_BACK);
  assign full     = (count_q == fmbq_pkg::CNT_W'(fmbq_pkg::CAPACITY));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - fmbq_pkg::CNT_W'(1);

  // Target position for the request kind at the current fill
  always_comb begin
    pos_d = '0;
    case (in_req_i.kind)
      fmbq_pkg::KIND_PUSH_MIDDLE: pos_d = count_q[fmbq_pkg::CNT_W-1:1];
      fmbq_pkg::KIND_PUSH_BACK:   pos_d = count_q[fmbq_pkg::IDX_W-1:0];
      fmbq_pkg::KIND_POP_MIDDLE:  pos_d = count_m1[fmbq_pkg::CNT_W-1:1];
      fmbq_pkg::KIND_POP_BACK:    pos_d = count_m1[fmbq_pkg::IDX_W-1:0];
      default:                    pos_d = '0;
    endcase
  end

  assign ptr_dec = ptr_q - fmbq_pkg::IDX_W'(1);
  assign ptr_inc = ptr_q + fmbq_pkg::IDX_W'(1);

  // Push shifts toward the back (cursor walks down), pop toward the front
  assign stat_o.push_ok     = push_ok_q;
  assign stat_o.pop_ok      = pop_ok_q;
  assign stat_o.at_end      = push_ok_q ? (ptr_q == pos_q) : (ptr_q == last_q);
  assign stat_o.next_at_end = push_ok_q ? (ptr_dec == pos_q) : (ptr_inc == last_q);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  assign rd_en   = cmd_i.fetch || cmd_i.move_rd;
  assign rd_addr = cmd_i.fetch ? ptr_q : (push_ok_q ? ptr_dec : ptr_inc);
  assign wr_en   = cmd_i.move_wr || cmd_i.place;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ptr_q] <= cmd_i.place ? value_q : rd_data_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      push_ok_q   <= 1'b0;
      pop_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        push_ok_q <= is_push && !full;
        pop_ok_q  <= is_pop && !empty;
      end
      if (cmd_i.place) begin
        count_q <= count_q + fmbq_pkg::CNT_W'(1);
      end else if (cmd_i.capture) begin
        count_q <= count_m1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= in_req_i.push_value;
      pos_q   <= pos_d;
      last_q  <= count_m1[fmbq_pkg::IDX_W-1:0];
      ptr_q   <= is_push ? count_q[fmbq_pkg::IDX_W-1:0] : pos_d;
      if (is_pop && empty) begin
        res_val_q <= fmbq_pkg::EMPTY_VALUE;
        res_st_q  <= fmbq_pkg::STATUS_EMPTY;
      end else if (is_push && full) begin
        res_val_q <= '0;
        res_st_q  <= fmbq_pkg::STATUS_FULL;
      end else begin
        res_val_q <= '0;
        res_st_q  <= fmbq_pkg::STATUS_OK;
      end
    end else if (cmd_i.move_wr) begin
      ptr_q <= push_ok_q ? ptr_dec : ptr_inc;
    end
    if (cmd_i.capture) begin
      res_val_q <= rd_data_q;
    end
    if (cmd_i.emit) begin
      out_rsp_q.pop_value <= res_val_q;
      out_rsp_q.status    <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
